@@ hw/rtl/rsdd_pkg.sv @@
// Shared constants and state types for the ring sort displacement distance block.
// No dependencies; used by rsdd_load, rsdd_disp and the top level.
`timescale 1ns / 1ps
`default_nettype none

package rsdd_pkg;

  // Fixed field widths of the transactions.
  localparam int ELEM_W      = 6;
  localparam int OUT_W       = 9;
  // Default permutation capacity.
  localparam int MAX_LEN_DEF = 32;

  // Loader sequencer.
  typedef enum logic [2:0] {
    LD_LOAD,
    LD_WAIT,
    LD_SCAN,
    LD_DRAIN,
    LD_FILL
  } load_state_t;

  // Displacement core sequencer.
  typedef enum logic [3:0] {
    DP_IDLE,
    DP_MSCAN,
    DP_MLAST,
    DP_MCHK,
    DP_WHI,
    DP_WLO,
    DP_CI,
    DP_CJ,
    DP_CEND,
    DP_DONE
  } disp_state_t;

  // What a read in flight on the displacement memory is for.
  typedef enum logic [1:0] {
    RK_BAL,
    RK_A,
    RK_B
  } rd_kind_t;

endpackage

`default_nettype wire

@@ hw/rtl/ring_sort_displacement_distance_top.sv @@
// Top level of the ring sort displacement distance block.
// Depends on rsdd_pkg, rsdd_load and rsdd_disp.
//
//   channel   direction  handshake              payload
//   elem      in         elem_valid/elem_ready  element[5:0], last
//   res       out        res_valid/res_ready    ring_inversions[8:0]
//
// Flow: the loader takes one element transaction per cycle while it is
// loading. On the last element it waits until the core is idle, then scans to
// locate each value and fills absent ones. The core runs balancing passes while
// a correction is needed, a final pass, then the pairwise count, which reads
// through the single read port of the displacement memory.
// Reset: rst clears both sequencers and the entry count; memories keep data.
// Stalls: a result holds in the core until taken; the loader keeps taking
// elements of the next permutation meanwhile and stalls only at its last one.
`timescale 1ns / 1ps
`default_nettype none

module ring_sort_displacement_distance_top #(
  parameter int MAX_LEN = rsdd_pkg::MAX_LEN_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         elem_valid,
  output logic                              elem_ready,
  input  wire logic [rsdd_pkg::ELEM_W-1:0]  element,
  input  wire logic                         last,
  output logic                              res_valid,
  input  wire logic                         res_ready,
  output logic [rsdd_pkg::OUT_W-1:0]        ring_inversions
);

  localparam int IDX_W = $clog2(MAX_LEN);
  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam int D_W   = CNT_W + 1;

  // Loader to core: displacement writes, start pulse and length.
  logic                  dw_en;
  logic [IDX_W-1:0]      dw_addr;
  logic signed [D_W-1:0] dw_data;
  logic                  start;
  logic [CNT_W-1:0]      n_len;
  logic                  disp_idle;

  // Store elements, then locate each value and hand displacements over.
  rsdd_load #(
    .MAX_LEN(MAX_LEN)
  ) u_load (
    .clk       (clk),
    .rst       (rst),
    .elem_valid(elem_valid),
    .elem_ready(elem_ready),
    .element   (element),
    .last      (last),
    .disp_idle (disp_idle),
    .dw_en     (dw_en),
    .dw_addr   (dw_addr),
    .dw_data   (dw_data),
    .start     (start),
    .n_len     (n_len)
  );

  // Balance the displacements, count ring inversions, hold the result.
  rsdd_disp #(
    .MAX_LEN(MAX_LEN)
  ) u_disp (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .n_in           (n_len),
    .dw_en          (dw_en),
    .dw_addr        (dw_addr),
    .dw_data        (dw_data),
    .idle           (disp_idle),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .ring_inversions(ring_inversions)
  );

endmodule

`default_nettype wire

@@ hw/rtl/rsdd_load.sv @@
// Loader: entry memory, entry counter and the position search that fills
// the displacement memory. Depends on rsdd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rsdd_load #(
  parameter int MAX_LEN = rsdd_pkg::MAX_LEN_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                elem_valid,
  output logic                                     elem_ready,
  input  wire logic [rsdd_pkg::ELEM_W-1:0]         element,
  input  wire logic                                last,
  input  wire logic                                disp_idle,
  output logic                                     dw_en,
  output logic [$clog2(MAX_LEN)-1:0]               dw_addr,
  output logic signed [$clog2(MAX_LEN+1):0]        dw_data,
  output logic                                     start,
  output logic [$clog2(MAX_LEN+1)-1:0]             n_len
);

  localparam int IDX_W  = $clog2(MAX_LEN);
  localparam int CNT_W  = $clog2(MAX_LEN + 1);
  localparam int D_W    = CNT_W + 1;
  localparam int ELEM_W = rsdd_pkg::ELEM_W;
  localparam int CMP_W  = (CNT_W > ELEM_W) ? CNT_W : ELEM_W;
  localparam int SEEN_N = 1 << IDX_W;

  rsdd_pkg::load_state_t state, state_next;

  logic [ELEM_W-1:0] entry_mem [MAX_LEN];

  logic [CNT_W-1:0]  count;
  logic [IDX_W-1:0]  idx;
  logic [SEEN_N-1:0] seen;
  logic              r_valid;
  logic [IDX_W-1:0]  r_idx;
  logic [ELEM_W-1:0] r_data;

  logic              accept;
  logic              count_add;
  logic [CNT_W-1:0]  n_m1;
  logic              idx_last;
  logic              rd_en;
  logic [ELEM_W-1:0] e_m1;
  logic [IDX_W-1:0]  e_idx;
  logic              hit;
  logic              fill_w;
  logic signed [D_W-1:0] scan_d;
  logic signed [D_W-1:0] fill_d;

  assign accept    = elem_valid && elem_ready;
  assign count_add = count < CNT_W'(MAX_LEN);
  assign n_m1      = n_len - 1'b1;
  assign idx_last  = idx == n_m1[IDX_W-1:0];

  // A value in 1..n not yet placed takes its first position.
  assign e_m1   = r_data - 1'b1;
  assign e_idx  = IDX_W'(e_m1);
  assign hit    = r_valid && (r_data != '0) && (CMP_W'(r_data) <= CMP_W'(n_len))
                  && !seen[e_idx];
  assign scan_d = D_W'(r_idx) + D_W'(1) - D_W'(r_data);

  // Absent values sit at position 1: displacement is minus the index.
  assign fill_w = (state == rsdd_pkg::LD_FILL) && !seen[idx];
  assign fill_d = D_W'(0) - D_W'(idx);

  assign dw_en   = hit || fill_w;
  assign dw_addr = hit ? e_idx : idx;
  assign dw_data = hit ? scan_d : fill_d;

  always_comb begin
    state_next = state;
    case (state)
      rsdd_pkg::LD_LOAD:  if (accept && last) state_next = rsdd_pkg::LD_WAIT;
      rsdd_pkg::LD_WAIT:  if (disp_idle) state_next = rsdd_pkg::LD_SCAN;
      rsdd_pkg::LD_SCAN:  if (idx_last) state_next = rsdd_pkg::LD_DRAIN;
      rsdd_pkg::LD_DRAIN: state_next = rsdd_pkg::LD_FILL;
      rsdd_pkg::LD_FILL:  if (idx_last) state_next = rsdd_pkg::LD_LOAD;
      default:            state_next = rsdd_pkg::LD_LOAD;
    endcase
  end

  always_comb begin
    elem_ready = 1'b0;
    rd_en      = 1'b0;
    start      = 1'b0;
    case (state)
      rsdd_pkg::LD_LOAD: elem_ready = 1'b1;
      rsdd_pkg::LD_SCAN: rd_en = 1'b1;
      rsdd_pkg::LD_FILL: start = idx_last;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= rsdd_pkg::LD_LOAD;
      count   <= '0;
      r_valid <= 1'b0;
    end else begin
      state   <= state_next;
      r_valid <= rd_en;
      if (accept) begin
        if (last) begin
          n_len <= count_add ? count + 1'b1 : count;
          count <= '0;
        end else if (count_add) begin
          count <= count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    r_idx <= idx;
    if (state == rsdd_pkg::LD_WAIT) begin
      idx <= '0;
    end else if (state == rsdd_pkg::LD_SCAN || state == rsdd_pkg::LD_FILL) begin
      idx <= idx_last ? '0 : idx + 1'b1;
    end
    if (accept && last) begin
      seen <= '0;
    end else if (hit) begin
      seen[e_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && count_add) begin
      entry_mem[count[IDX_W-1:0]] <= element;
    end
    if (rd_en) begin
      r_data <= entry_mem[idx];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/rsdd_disp.sv @@
// Displacement core: displacement memory, balancing passes and the pairwise
// ring inversion count with its result register. Depends on rsdd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rsdd_disp #(
  parameter int MAX_LEN = rsdd_pkg::MAX_LEN_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  input  wire logic [$clog2(MAX_LEN+1)-1:0]         n_in,
  input  wire logic                                 dw_en,
  input  wire logic [$clog2(MAX_LEN)-1:0]           dw_addr,
  input  wire logic signed [$clog2(MAX_LEN+1):0]    dw_data,
  output logic                                      idle,
  output logic                                      res_valid,
  input  wire logic                                 res_ready,
  output logic [rsdd_pkg::OUT_W-1:0]                ring_inversions
);

  localparam int IDX_W = $clog2(MAX_LEN);
  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam int D_W   = CNT_W + 1;
  localparam int S_W   = CNT_W + 3;

  rsdd_pkg::disp_state_t state, state_next;

  logic signed [D_W-1:0] disp_mem [MAX_LEN];

  logic [CNT_W-1:0]          n_len;
  logic [IDX_W-1:0]          addr;
  logic [IDX_W-1:0]          i_idx;
  logic                      r_valid;
  rsdd_pkg::rd_kind_t        r_kind;
  logic [IDX_W-1:0]          r_idx;
  logic signed [D_W-1:0]     r_data;
  logic signed [D_W-1:0]     d_max;
  logic signed [D_W-1:0]     d_min;
  logic [IDX_W-1:0]          hi;
  logic [IDX_W-1:0]          lo;
  logic signed [S_W-1:0]     a_val;
  logic [rsdd_pkg::OUT_W-1:0] count;

  logic [CNT_W-1:0]          n_m1;
  logic [CNT_W-1:0]          n_m2;
  logic                      addr_last;
  logic                      i_end;
  logic                      rd_en;
  logic [IDX_W-1:0]          rd_addr;
  rsdd_pkg::rd_kind_t        rd_kind;
  logic                      we;
  logic [IDX_W-1:0]          waddr;
  logic signed [D_W-1:0]     wdata;
  logic signed [S_W-1:0]     n_s;
  logic signed [S_W-1:0]     idx_s;
  logic signed [S_W-1:0]     d_s;
  logic signed [S_W-1:0]     b_val;
  logic signed [S_W-1:0]     span;
  logic                      exceed;
  logic                      inv;

  assign n_m1      = n_len - 1'b1;
  assign n_m2      = n_len - 2'd2;
  assign addr_last = addr == n_m1[IDX_W-1:0];
  assign i_end     = i_idx == n_m2[IDX_W-1:0];

  assign n_s    = S_W'(n_len);
  assign idx_s  = S_W'(r_idx);
  assign d_s    = S_W'(r_data);
  assign b_val  = idx_s + d_s;
  assign span   = S_W'(d_max) - S_W'(d_min);
  assign exceed = span > n_s;
  assign inv    = (a_val > b_val) || (a_val + n_s < b_val);

  always_comb begin
    state_next = state;
    case (state)
      rsdd_pkg::DP_IDLE:  if (start) state_next = rsdd_pkg::DP_MSCAN;
      rsdd_pkg::DP_MSCAN: if (addr_last) state_next = rsdd_pkg::DP_MLAST;
      rsdd_pkg::DP_MLAST: state_next = rsdd_pkg::DP_MCHK;
      rsdd_pkg::DP_MCHK: begin
        if (exceed) begin
          state_next = rsdd_pkg::DP_WHI;
        end else if (n_len == CNT_W'(1)) begin
          state_next = rsdd_pkg::DP_DONE;
        end else begin
          state_next = rsdd_pkg::DP_CI;
        end
      end
      rsdd_pkg::DP_WHI:   state_next = rsdd_pkg::DP_WLO;
      rsdd_pkg::DP_WLO:   state_next = rsdd_pkg::DP_MSCAN;
      rsdd_pkg::DP_CI:    state_next = rsdd_pkg::DP_CJ;
      rsdd_pkg::DP_CJ: begin
        if (addr_last) begin
          state_next = i_end ? rsdd_pkg::DP_CEND : rsdd_pkg::DP_CI;
        end
      end
      rsdd_pkg::DP_CEND:  state_next = rsdd_pkg::DP_DONE;
      rsdd_pkg::DP_DONE:  if (res_ready) state_next = rsdd_pkg::DP_IDLE;
      default:            state_next = rsdd_pkg::DP_IDLE;
    endcase
  end

  always_comb begin
    idle      = 1'b0;
    res_valid = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = addr;
    rd_kind   = rsdd_pkg::RK_B;
    we        = dw_en;
    waddr     = dw_addr;
    wdata     = dw_data;
    case (state)
      rsdd_pkg::DP_IDLE: idle = 1'b1;
      rsdd_pkg::DP_MSCAN: begin
        rd_en   = 1'b1;
        rd_kind = rsdd_pkg::RK_BAL;
      end
      rsdd_pkg::DP_WHI: begin
        we    = 1'b1;
        waddr = hi;
        wdata = d_max - D_W'(n_len);
      end
      rsdd_pkg::DP_WLO: begin
        we    = 1'b1;
        waddr = lo;
        wdata = d_min + D_W'(n_len);
      end
      rsdd_pkg::DP_CI: begin
        rd_en   = 1'b1;
        rd_addr = i_idx;
        rd_kind = rsdd_pkg::RK_A;
      end
      rsdd_pkg::DP_CJ: rd_en = 1'b1;
      rsdd_pkg::DP_DONE: res_valid = 1'b1;
      default: ;
    endcase
  end

  assign ring_inversions = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= rsdd_pkg::DP_IDLE;
      r_valid <= 1'b0;
    end else begin
      state   <= state_next;
      r_valid <= rd_en;
    end
  end

  // Sequencer counters.
  always_ff @(posedge clk) begin
    r_kind <= rd_kind;
    r_idx  <= rd_addr;
    case (state)
      rsdd_pkg::DP_IDLE: begin
        n_len <= n_in;
        addr  <= '0;
        count <= '0;
      end
      rsdd_pkg::DP_MSCAN: addr <= addr + 1'b1;
      rsdd_pkg::DP_MCHK:  i_idx <= '0;
      rsdd_pkg::DP_WLO:   addr <= '0;
      rsdd_pkg::DP_CI:    addr <= i_idx + 1'b1;
      rsdd_pkg::DP_CJ: begin
        addr <= addr + 1'b1;
        if (addr_last) i_idx <= i_idx + 1'b1;
      end
      default: ;
    endcase
    // Consume the registered read data.
    if (r_valid) begin
      case (r_kind)
        rsdd_pkg::RK_BAL: begin
          if (r_idx == '0 || r_data > d_max) begin
            d_max <= r_data;
            hi    <= r_idx;
          end
          if (r_idx == '0 || r_data < d_min) begin
            d_min <= r_data;
            lo    <= r_idx;
          end
        end
        rsdd_pkg::RK_A: a_val <= b_val;
        rsdd_pkg::RK_B: if (inv) count <= count + 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      disp_mem[waddr] <= wdata;
    end
    if (rd_en) begin
      r_data <= disp_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire
